// ===== rtl/core/dwmt_pkg.sv =====
// Shared types and constants for the delay window min tracker.
// Standalone package; used by delay_window_min_tracker.
`default_nettype none

package dwmt_pkg;

   // Field widths
   localparam int RTT_W   = 32;
   localparam int NOW_W   = 48;
   localparam int DELAY_W = 22;
   localparam int IVL_W   = 32;

   // Default ring lengths
   localparam int DEF_HISTORY_LEN = 10;
   localparam int DEF_FILTER_LEN  = 4;

   // Reset value of the rollover interval, 60 s in ms
   localparam logic [IVL_W-1:0] INTERVAL_RESET = 32'd60000;

   // floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for 0 <= x < 2^31
   localparam logic [31:0] RECIP_1000  = 32'd2199023256;
   localparam int          RECIP_SHIFT = 41;
   localparam int          PROD_W      = 63;

   // Larger than any delay the block can hold; seeds a rescan
   localparam logic [DELAY_W-1:0] DELAY_MAX = '1;

   typedef struct packed {
      logic signed [RTT_W-1:0] rtt_us;
      logic [NOW_W-1:0]        now_ms;
   } req_beat_type;

   typedef struct packed {
      logic               sample_taken;
      logic               current_valid;
      logic [DELAY_W-1:0] current_delay_ms;
      logic               base_valid;
      logic [DELAY_W-1:0] base_delay_ms;
      logic [DELAY_W-1:0] queue_delay_ms;
   } rsp_beat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE,
      ST_RPUSH,
      ST_RSCAN,
      ST_ROLL,
      ST_HPUSH,
      ST_HLAST,
      ST_HMIN,
      ST_HSCAN,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/delay_window_min_tracker.sv =====
// Delay window min tracker: recent and base round-trip minimum filter.
// Depends on dwmt_pkg for beat types, state encoding and constants.
//
// Each request beat carries a round trip in us and a time in ms and yields exactly one
// response beat. A non-positive round trip is ignored. A positive one is scaled to ms by
// a reciprocal multiply, pushed into the recent ring (FILTER_LEN entries) and folded
// into the base history (HISTORY_LEN slots, one per rollover interval); a rescan of the
// recent ring follows when its minimum is evicted, and a rescan of the history when the
// history minimum is evicted. The rescans step one slot per cycle through a single
// shared comparator. req_stall stays high while a beat is in work; the response sits in
// an output register, so the next request can be taken while it waits on rsp_stall.
// Write csr_wr_data to set the rollover interval only while idle; there is no clearing
// pass after reset.
`default_nettype none

module delay_window_min_tracker #(
   parameter int HISTORY_LEN = dwmt_pkg::DEF_HISTORY_LEN,
   parameter int FILTER_LEN  = dwmt_pkg::DEF_FILTER_LEN
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_stall,
   input  dwmt_pkg::req_beat_type          req_beat,
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output dwmt_pkg::rsp_beat_type          rsp_beat,
   input  wire                             csr_wr_en,
   input  wire [dwmt_pkg::IVL_W-1:0]       csr_wr_data
);

   localparam int R_SLOTS = FILTER_LEN + 1;
   localparam int H_SLOTS = HISTORY_LEN + 1;
   localparam int RIDX_W  = $clog2(R_SLOTS);
   localparam int HIDX_W  = $clog2(H_SLOTS);
   localparam int SCAN_W  = (RIDX_W > HIDX_W) ? RIDX_W : HIDX_W;
   localparam logic [RIDX_W-1:0] R_LAST = RIDX_W'(R_SLOTS - 1);
   localparam logic [HIDX_W-1:0] H_LAST = HIDX_W'(H_SLOTS - 1);
   localparam int DW = dwmt_pkg::DELAY_W;

   function automatic logic [RIDX_W-1:0] r_next(input logic [RIDX_W-1:0] idx);
      r_next = (idx == R_LAST) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [HIDX_W-1:0] h_next(input logic [HIDX_W-1:0] idx);
      h_next = (idx == H_LAST) ? '0 : idx + 1'b1;
   endfunction

   // Sample stores
   logic [DW-1:0] r_mem [R_SLOTS];
   logic [DW-1:0] h_mem [H_SLOTS];

   // Sequencer and beat registers
   dwmt_pkg::state_type    state_ff, state_in;
   dwmt_pkg::req_beat_type req_ff;
   logic                   taken_ff;
   logic [DW-1:0]          ms_ff;

   // Recent ring
   logic [RIDX_W-1:0] r_head_ff, r_tail_ff, r_min_slot_ff;
   logic [DW-1:0]     r_min_val_ff;
   logic [DW-1:0]     r_rd_ff;

   // Base history
   logic [HIDX_W-1:0] h_head_ff, h_tail_ff, h_min_slot_ff;
   logic [DW-1:0]     h_min_val_ff;
   logic [DW-1:0]     h_last_val_ff;
   logic [DW-1:0]     h_rd_ff;
   logic [dwmt_pkg::NOW_W-1:0] roll_start_ff;
   logic [dwmt_pkg::IVL_W-1:0] interval_ff;

   // Rescan pipeline
   logic [SCAN_W-1:0] scan_idx_ff;
   logic              scan_issue_ff;
   logic [SCAN_W-1:0] rd_idx_ff;
   logic              rd_vld_ff;

   // Response register
   logic                   rsp_valid_ff;
   dwmt_pkg::rsp_beat_type rsp_ff;

   // Shared comparator
   logic [DW-1:0] cmp_a, cmp_b;
   logic          cmp_lt;

   // Control decode
   logic                   req_take;
   logic                   rsp_load;
   logic                   sample_pos;
   logic [dwmt_pkg::PROD_W-1:0] prod;
   logic                   r_empty, r_full_after, r_rescan;
   logic [RIDX_W-1:0]      r_tail_nx, r_head_nx;
   logic                   h_empty, h_full_after, h_rescan;
   logic [HIDX_W-1:0]      h_tail_nx, h_head_nx, h_last_idx;
   logic [dwmt_pkg::NOW_W-1:0] start_eff, elapsed;
   logic                   roll_due, h_do_push;
   logic [SCAN_W-1:0]      scan_next, scan_end;
   logic                   scan_done;
   dwmt_pkg::rsp_beat_type rsp_in;

   assign cmp_lt = cmp_a < cmp_b;

   assign sample_pos = !req_beat.rtt_us[dwmt_pkg::RTT_W-1] && (req_beat.rtt_us != '0);
   assign prod = dwmt_pkg::PROD_W'(req_ff.rtt_us[dwmt_pkg::RTT_W-2:0])
               * dwmt_pkg::PROD_W'(dwmt_pkg::RECIP_1000);

   // Ring bookkeeping
   assign r_empty      = r_head_ff == r_tail_ff;
   assign r_tail_nx    = r_next(r_tail_ff);
   assign r_head_nx    = r_next(r_head_ff);
   assign r_full_after = r_tail_nx == r_head_ff;
   assign r_rescan     = !r_empty && r_full_after && !cmp_lt && (r_min_slot_ff == r_head_ff);

   assign h_empty      = h_head_ff == h_tail_ff;
   assign h_tail_nx    = h_next(h_tail_ff);
   assign h_head_nx    = h_next(h_head_ff);
   assign h_full_after = h_tail_nx == h_head_ff;
   assign h_rescan     = !h_empty && h_full_after && !cmp_lt && (h_min_slot_ff == h_head_ff);
   assign h_last_idx   = (h_tail_ff == '0) ? H_LAST : h_tail_ff - 1'b1;

   // Rollover test: latch the start on first use, then compare elapsed time
   assign start_eff = (roll_start_ff == '0) ? req_ff.now_ms : roll_start_ff;
   assign elapsed   = req_ff.now_ms - start_eff;
   assign roll_due  = elapsed > dwmt_pkg::NOW_W'(interval_ff);
   assign h_do_push = h_empty || roll_due;

   // Rescan index stepping
   always_comb begin
      if (state_ff == dwmt_pkg::ST_RSCAN) begin
         scan_next = SCAN_W'(r_next(scan_idx_ff[RIDX_W-1:0]));
         scan_end  = SCAN_W'(r_tail_ff);
      end else begin
         scan_next = SCAN_W'(h_next(scan_idx_ff[HIDX_W-1:0]));
         scan_end  = SCAN_W'(h_tail_ff);
      end
   end
   assign scan_done = rd_vld_ff && !scan_issue_ff;

   assign rsp_load = (state_ff == dwmt_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dwmt_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = sample_pos ? dwmt_pkg::ST_SCALE : dwmt_pkg::ST_DONE;
            end
         end
         dwmt_pkg::ST_SCALE: state_in = dwmt_pkg::ST_RPUSH;
         dwmt_pkg::ST_RPUSH: state_in = r_rescan ? dwmt_pkg::ST_RSCAN : dwmt_pkg::ST_ROLL;
         dwmt_pkg::ST_RSCAN: begin
            if (scan_done) begin
               state_in = dwmt_pkg::ST_ROLL;
            end
         end
         dwmt_pkg::ST_ROLL:  state_in = h_do_push ? dwmt_pkg::ST_HPUSH : dwmt_pkg::ST_HLAST;
         dwmt_pkg::ST_HPUSH: state_in = h_rescan ? dwmt_pkg::ST_HSCAN : dwmt_pkg::ST_DONE;
         dwmt_pkg::ST_HLAST: state_in = cmp_lt ? dwmt_pkg::ST_HMIN : dwmt_pkg::ST_DONE;
         dwmt_pkg::ST_HMIN:  state_in = dwmt_pkg::ST_DONE;
         dwmt_pkg::ST_HSCAN: begin
            if (scan_done) begin
               state_in = dwmt_pkg::ST_DONE;
            end
         end
         dwmt_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = dwmt_pkg::ST_IDLE;
            end
         end
         default: state_in = dwmt_pkg::ST_IDLE;
      endcase
   end

   // State outputs: handshake and comparator operand select
   always_comb begin
      req_stall = (state_ff != dwmt_pkg::ST_IDLE);
      cmp_a     = ms_ff;
      cmp_b     = r_min_val_ff;
      case (state_ff)
         dwmt_pkg::ST_RPUSH: begin
            cmp_a = ms_ff;
            cmp_b = r_min_val_ff;
         end
         dwmt_pkg::ST_RSCAN: begin
            cmp_a = r_rd_ff;
            cmp_b = r_min_val_ff;
         end
         dwmt_pkg::ST_HPUSH: begin
            cmp_a = ms_ff;
            cmp_b = h_min_val_ff;
         end
         dwmt_pkg::ST_HLAST: begin
            cmp_a = ms_ff;
            cmp_b = h_last_val_ff;
         end
         dwmt_pkg::ST_HMIN: begin
            cmp_a = ms_ff;
            cmp_b = h_min_val_ff;
         end
         dwmt_pkg::ST_HSCAN: begin
            cmp_a = h_rd_ff;
            cmp_b = h_min_val_ff;
         end
         default: begin
            cmp_a = ms_ff;
            cmp_b = r_min_val_ff;
         end
      endcase
   end
   assign req_take = req_valid && !req_stall;

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dwmt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= dwmt_pkg::INTERVAL_RESET;
      end else if (csr_wr_en) begin
         interval_ff <= csr_wr_data;
      end
   end

   // Capture the request beat and scale to ms
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff   <= req_beat;
         taken_ff <= sample_pos;
      end
      if (state_ff == dwmt_pkg::ST_SCALE) begin
         ms_ff <= prod[dwmt_pkg::RECIP_SHIFT +: DW];
      end
   end

   // Recent store: write on push, registered read during rescan
   always_ff @(posedge clock) begin
      if (state_ff == dwmt_pkg::ST_RPUSH) begin
         r_mem[r_tail_ff] <= ms_ff;
      end
      if (state_ff == dwmt_pkg::ST_RSCAN && scan_issue_ff) begin
         r_rd_ff <= r_mem[scan_idx_ff[RIDX_W-1:0]];
      end
   end

   // History store: write on push or last-slot update, registered read during rescan
   always_ff @(posedge clock) begin
      if (state_ff == dwmt_pkg::ST_HPUSH) begin
         h_mem[h_tail_ff] <= ms_ff;
      end else if (state_ff == dwmt_pkg::ST_HLAST && cmp_lt) begin
         h_mem[h_last_idx] <= ms_ff;
      end
      if (state_ff == dwmt_pkg::ST_HSCAN && scan_issue_ff) begin
         h_rd_ff <= h_mem[scan_idx_ff[HIDX_W-1:0]];
      end
   end

   // Minimum values and last-slot value
   always_ff @(posedge clock) begin
      case (state_ff)
         dwmt_pkg::ST_RPUSH: begin
            if (r_empty || cmp_lt) begin
               r_min_val_ff <= ms_ff;
            end else if (r_rescan) begin
               r_min_val_ff <= dwmt_pkg::DELAY_MAX;
            end
         end
         dwmt_pkg::ST_RSCAN: begin
            if (rd_vld_ff && cmp_lt) begin
               r_min_val_ff <= r_rd_ff;
            end
         end
         dwmt_pkg::ST_HPUSH: begin
            h_last_val_ff <= ms_ff;
            if (h_empty || cmp_lt) begin
               h_min_val_ff <= ms_ff;
            end else if (h_rescan) begin
               h_min_val_ff <= dwmt_pkg::DELAY_MAX;
            end
         end
         dwmt_pkg::ST_HLAST: begin
            if (cmp_lt) begin
               h_last_val_ff <= ms_ff;
            end
         end
         dwmt_pkg::ST_HMIN: begin
            if (cmp_lt) begin
               h_min_val_ff <= ms_ff;
            end
         end
         dwmt_pkg::ST_HSCAN: begin
            if (rd_vld_ff && cmp_lt) begin
               h_min_val_ff <= h_rd_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Ring pointers, min slots, rollover start and rescan control
   always_ff @(posedge clock) begin
      if (reset) begin
         r_head_ff     <= '0;
         r_tail_ff     <= '0;
         r_min_slot_ff <= '0;
         h_head_ff     <= '0;
         h_tail_ff     <= '0;
         h_min_slot_ff <= '0;
         roll_start_ff <= '0;
         scan_idx_ff   <= '0;
         scan_issue_ff <= 1'b0;
         rd_idx_ff     <= '0;
         rd_vld_ff     <= 1'b0;
      end else begin
         case (state_ff)
            dwmt_pkg::ST_RPUSH: begin
               r_tail_ff <= r_tail_nx;
               if (r_empty || cmp_lt) begin
                  r_min_slot_ff <= r_tail_ff;
               end
               // Drop the oldest slot once the ring wraps onto it
               if (!r_empty && r_full_after) begin
                  r_head_ff <= r_head_nx;
               end
               if (r_rescan) begin
                  scan_idx_ff   <= SCAN_W'(r_head_nx);
                  scan_issue_ff <= 1'b1;
                  rd_vld_ff     <= 1'b0;
               end
            end
            dwmt_pkg::ST_ROLL: begin
               roll_start_ff <= (!h_empty && roll_due) ? req_ff.now_ms : start_eff;
            end
            dwmt_pkg::ST_HPUSH: begin
               h_tail_ff <= h_tail_nx;
               if (h_empty || cmp_lt) begin
                  h_min_slot_ff <= h_tail_ff;
               end
               if (!h_empty && h_full_after) begin
                  h_head_ff <= h_head_nx;
               end
               if (h_rescan) begin
                  scan_idx_ff   <= SCAN_W'(h_head_nx);
                  scan_issue_ff <= 1'b1;
                  rd_vld_ff     <= 1'b0;
               end
            end
            dwmt_pkg::ST_HMIN: begin
               if (cmp_lt) begin
                  h_min_slot_ff <= h_last_idx;
               end
            end
            dwmt_pkg::ST_RSCAN, dwmt_pkg::ST_HSCAN: begin
               // Issue one read per cycle, compare the one returned last cycle
               rd_vld_ff <= scan_issue_ff;
               rd_idx_ff <= scan_idx_ff;
               if (scan_issue_ff) begin
                  scan_idx_ff <= scan_next;
                  if (scan_next == scan_end) begin
                     scan_issue_ff <= 1'b0;
                  end
               end
               if (rd_vld_ff && cmp_lt) begin
                  if (state_ff == dwmt_pkg::ST_RSCAN) begin
                     r_min_slot_ff <= rd_idx_ff[RIDX_W-1:0];
                  end else begin
                     h_min_slot_ff <= rd_idx_ff[HIDX_W-1:0];
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Build the response beat from the current state
   always_comb begin
      rsp_in.sample_taken     = taken_ff;
      rsp_in.current_valid    = !r_empty;
      rsp_in.current_delay_ms = r_empty ? '0 : r_min_val_ff;
      rsp_in.base_valid       = !h_empty;
      rsp_in.base_delay_ms    = h_empty ? '0 : h_min_val_ff;
      rsp_in.queue_delay_ms   = '0;
      if (!r_empty && !h_empty && (r_min_val_ff > h_min_val_ff)) begin
         rsp_in.queue_delay_ms = r_min_val_ff - h_min_val_ff;
      end
   end

   // Response register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

endmodule

`default_nettype wire
